@@ hw/rtl/prs_pkg.sv @@
// ---------------------------------------------------------------------------
// prs_pkg
// Shared constants, command codes and control structs of the route search.
// ---------------------------------------------------------------------------
package prs_pkg;

    localparam int MAX_PASSENGERS = 11;
    localparam int DIST_BITS      = 16;
    localparam int NUM_POINTS     = 2 * MAX_PASSENGERS + 1;
    localparam int RAM_DEPTH      = NUM_POINTS * NUM_POINTS;
    localparam int ADDR_BITS      = $clog2(RAM_DEPTH);
    localparam int PT_BITS        = 5;
    localparam int CNT_BITS       = 4;
    localparam int COST_BITS      = 21;
    localparam int IDX_BITS       = 4;

    localparam logic [COST_BITS-1:0] COST_MAX   = {COST_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0] PT_STRIDE  = ADDR_BITS'(NUM_POINTS);
    localparam logic [PT_BITS-1:0]   PT_LIMIT   = PT_BITS'(NUM_POINTS);
    localparam logic [CNT_BITS-1:0]  N_LIMIT    = CNT_BITS'(MAX_PASSENGERS);

    localparam logic [IDX_BITS-1:0]  REG_PASSENGERS = 4'd0;
    localparam logic [IDX_BITS-1:0]  REG_SEATS      = 4'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_SRCH_INIT,
        OP_POP,
        OP_ADV,
        OP_EVAL_RD,
        OP_COMMIT,
        OP_LEAF_RD,
        OP_LEAF_CMP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic n_zero;
        logic idx_over;
        logic depth_one;
        logic can_pick;
        logic can_drop;
        logic go_leaf;
    } sts_t;

endpackage

@@ hw/rtl/prs_in_if.sv @@
// ---------------------------------------------------------------------------
// prs_in_if
// Input channel: matrix loads and search starts.
// ---------------------------------------------------------------------------
interface prs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] row;
    logic [4:0] col;
    logic [15:0] distance;

    modport source (output valid, kind, row, col, distance, input ready);
    modport sink (input valid, kind, row, col, distance, output ready);
endinterface

@@ hw/rtl/prs_out_if.sv @@
// ---------------------------------------------------------------------------
// prs_out_if
// Result channel: best route cost and found flag.
// ---------------------------------------------------------------------------
interface prs_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] best_cost;
    logic        found;

    modport source (output valid, best_cost, found, input ready);
    modport sink (input valid, best_cost, found, output ready);
endinterface

@@ hw/rtl/prs_cfg_if.sv @@
// ---------------------------------------------------------------------------
// prs_cfg_if
// Configuration write channel.
// ---------------------------------------------------------------------------
interface prs_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/prs_ram.sv @@
// ---------------------------------------------------------------------------
// prs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module prs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 529
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/prs_dp.sv @@
// ---------------------------------------------------------------------------
// prs_dp
// Search datapath: distance RAM, route stacks, cost and bound arithmetic.
// ---------------------------------------------------------------------------
module prs_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  prs_pkg::cmd_t                      cmd,
    output prs_pkg::sts_t                      sts,
    input  logic [4:0]                         row,
    input  logic [4:0]                         col,
    input  logic [15:0]                        distance,
    input  logic                               cfg_we,
    input  logic [prs_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [3:0]                         cfg_data,
    output logic [prs_pkg::COST_BITS-1:0]      best_cost,
    output logic                               found
);

    localparam int PB = prs_pkg::PT_BITS;
    localparam int CB = prs_pkg::COST_BITS;
    localparam int AB = prs_pkg::ADDR_BITS;
    localparam int NB = prs_pkg::CNT_BITS;
    localparam int DB = prs_pkg::DIST_BITS;
    localparam int NP = prs_pkg::NUM_POINTS;

    logic [NB-1:0] pass_reg, seats_reg;
    logic [PB-1:0] a_reg, b_reg, d_reg, cur_reg;
    logic [DB-1:0] min_reg;
    logic [NP-1:0] vis_reg;
    logic [PB-1:0] route_reg [NP];
    logic [PB-1:0] idx_reg [NP];
    logic [CB-1:0] cstk_reg [NP];
    logic [CB-1:0] cost_reg, best_reg, tmp_reg, out_cost_reg;
    logic [CB-1:0] prod_reg;
    logic [NB-1:0] load_reg;
    logic          pick_reg, out_found_reg;

    logic [NB-1:0] n_eff;
    logic [PB-1:0] last, dm1, drop_src, prev_pt;
    logic          ram_we;
    logic [AB-1:0] waddr, raddr;
    logic [DB-1:0] rdata;
    logic [CB-1:0] newc;
    logic [CB:0]   bound, total;

    assign n_eff    = (pass_reg > prs_pkg::N_LIMIT) ? prs_pkg::N_LIMIT : pass_reg;
    assign last     = {n_eff, 1'b0};
    assign dm1      = d_reg - 5'd1;
    assign drop_src = cur_reg - PB'(n_eff);
    assign prev_pt  = route_reg[dm1];

    assign ram_we = (cmd.op == prs_pkg::OP_WRITE) &&
                    (row < prs_pkg::PT_LIMIT) && (col < prs_pkg::PT_LIMIT);
    assign waddr  = AB'(AB'(row) * prs_pkg::PT_STRIDE + AB'(col));

    always_comb
    begin
        case (cmd.op)
            prs_pkg::OP_EVAL_RD: raddr = AB'(AB'(prev_pt) * prs_pkg::PT_STRIDE + AB'(cur_reg));
            prs_pkg::OP_LEAF_RD: raddr = AB'(AB'(cur_reg) * prs_pkg::PT_STRIDE);
            default:             raddr = AB'(AB'(a_reg) * prs_pkg::PT_STRIDE + AB'(b_reg));
        endcase
    end

    prs_ram #(.WIDTH(DB), .DEPTH(prs_pkg::RAM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (distance),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign newc  = cost_reg + CB'(rdata);
    assign bound = {1'b0, newc} + {1'b0, prod_reg};
    assign total = {1'b0, tmp_reg} + (CB+1)'(rdata);

    always_comb
    begin
        sts.scan_done = (a_reg == last) && (b_reg == last);
        sts.n_zero    = (n_eff == '0);
        sts.idx_over  = (cur_reg > last);
        sts.depth_one = (d_reg == 5'd1);
        sts.can_pick  = (cur_reg < prs_pkg::PT_LIMIT) && !vis_reg[cur_reg] &&
                        (cur_reg <= PB'(n_eff)) && (load_reg < seats_reg) && (d_reg < last);
        sts.can_drop  = (cur_reg < prs_pkg::PT_LIMIT) && !vis_reg[cur_reg] &&
                        (cur_reg > PB'(n_eff)) && (drop_src < prs_pkg::PT_LIMIT) &&
                        vis_reg[drop_src];
        sts.go_leaf   = !pick_reg && (d_reg == last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg      <= 4'd1;
            seats_reg     <= 4'd1;
            a_reg         <= '0;
            b_reg         <= '0;
            d_reg         <= 5'd1;
            cur_reg       <= '0;
            min_reg       <= '1;
            vis_reg       <= NP'(1);
            cost_reg      <= '0;
            best_reg      <= prs_pkg::COST_MAX;
            load_reg      <= '0;
            pick_reg      <= 1'b0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == prs_pkg::REG_PASSENGERS)
            begin
                pass_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == prs_pkg::REG_SEATS)
            begin
                seats_reg <= cfg_data;
            end
            case (cmd.op)
                prs_pkg::OP_SCAN_INIT:
                begin
                    a_reg    <= '0;
                    b_reg    <= '0;
                    min_reg  <= '1;
                    best_reg <= prs_pkg::COST_MAX;
                    vis_reg  <= NP'(1);
                    cost_reg <= '0;
                    load_reg <= '0;
                end
                prs_pkg::OP_SCAN_CMP:
                begin
                    if (a_reg != b_reg && rdata < min_reg)
                    begin
                        min_reg <= rdata;
                    end
                    if (b_reg == last)
                    begin
                        b_reg <= '0;
                        a_reg <= a_reg + 5'd1;
                    end
                    else
                    begin
                        b_reg <= b_reg + 5'd1;
                    end
                end
                prs_pkg::OP_SRCH_INIT:
                begin
                    d_reg   <= 5'd1;
                    cur_reg <= 5'd1;
                end
                prs_pkg::OP_ADV:
                begin
                    cur_reg <= cur_reg + 5'd1;
                end
                prs_pkg::OP_POP:
                begin
                    d_reg <= dm1;
                    if (dm1 != '0)
                    begin
                        cost_reg         <= cstk_reg[dm1];
                        vis_reg[prev_pt] <= 1'b0;
                        cur_reg          <= idx_reg[dm1] + 5'd1;
                        if (prev_pt <= PB'(n_eff))
                        begin
                            load_reg <= load_reg - 4'd1;
                        end
                        else
                        begin
                            load_reg <= load_reg + 4'd1;
                        end
                    end
                end
                prs_pkg::OP_EVAL_RD:
                begin
                    pick_reg <= sts.can_pick;
                    prod_reg <= CB'(last + 5'd1 - d_reg) * CB'(min_reg);
                end
                prs_pkg::OP_COMMIT:
                begin
                    if (pick_reg || (d_reg < last && bound < {1'b0, best_reg}))
                    begin
                        vis_reg[cur_reg] <= 1'b1;
                        cost_reg         <= newc;
                        d_reg            <= d_reg + 5'd1;
                        cur_reg          <= 5'd1;
                        load_reg         <= pick_reg ? load_reg + 4'd1 : load_reg - 4'd1;
                    end
                    else if (d_reg == last)
                    begin
                        tmp_reg <= newc;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 5'd1;
                    end
                end
                prs_pkg::OP_LEAF_CMP:
                begin
                    if (total < {1'b0, best_reg})
                    begin
                        best_reg <= total[CB-1:0];
                    end
                    cur_reg <= cur_reg + 5'd1;
                end
                prs_pkg::OP_FINISH:
                begin
                    out_found_reg <= (best_reg != prs_pkg::COST_MAX);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stack contents and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            prs_pkg::OP_SRCH_INIT:
            begin
                route_reg[0] <= '0;
            end
            prs_pkg::OP_COMMIT:
            begin
                if (pick_reg || (d_reg < last && bound < {1'b0, best_reg}))
                begin
                    route_reg[d_reg] <= cur_reg;
                    idx_reg[d_reg]   <= cur_reg;
                    cstk_reg[d_reg]  <= cost_reg;
                end
            end
            prs_pkg::OP_FINISH:
            begin
                out_cost_reg <= best_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign best_cost = out_cost_reg;
    assign found     = out_found_reg;

`ifndef SYNTH
    a_depot_visited: assert property (@(posedge clk) disable iff (!rst_n) vis_reg[0])
        else $error("depot dropped from visited set");
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg < prs_pkg::PT_LIMIT)
        else $error("search depth out of range");
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_reg <= prs_pkg::N_LIMIT)
        else $error("bus load out of range");
`endif

endmodule

@@ hw/rtl/prs_ctrl.sv @@
// ---------------------------------------------------------------------------
// prs_ctrl
// Sequencer of the search: matrix scan, depth-first walk, result hand-off.
// ---------------------------------------------------------------------------
module prs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_kind,
    output logic          out_valid,
    input  logic          out_ready,
    output prs_pkg::cmd_t cmd,
    input  prs_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INIT,
        S_EVAL,
        S_COMMIT,
        S_LEAF_RD,
        S_LEAF_CMP
    } state_t;

    localparam state_t S_DONE_ALIAS = S_IDLE;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   done_reg, done_next;

    assign in_ready = (state_reg == S_IDLE) && !done_reg;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = prs_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.op         = prs_pkg::OP_FINISH;
                        out_valid_next = 1'b1;
                        done_next      = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    if (in_kind == prs_pkg::KIND_START)
                    begin
                        cmd.op     = prs_pkg::OP_SCAN_INIT;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        cmd.op = prs_pkg::OP_WRITE;
                    end
                end
            end
            S_SCAN_RD:
            begin
                cmd.op     = prs_pkg::OP_SCAN_RD;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.op = prs_pkg::OP_SCAN_CMP;
                if (!sts.scan_done)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (sts.n_zero)
                begin
                    state_next = S_DONE_ALIAS;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op     = prs_pkg::OP_SRCH_INIT;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.idx_over)
                begin
                    cmd.op = prs_pkg::OP_POP;
                    if (sts.depth_one)
                    begin
                        state_next = S_DONE_ALIAS;
                        done_next  = 1'b1;
                    end
                end
                else if (sts.can_pick || sts.can_drop)
                begin
                    cmd.op     = prs_pkg::OP_EVAL_RD;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.op = prs_pkg::OP_ADV;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = prs_pkg::OP_COMMIT;
                state_next = sts.go_leaf ? S_LEAF_RD : S_EVAL;
            end
            S_LEAF_RD:
            begin
                cmd.op     = prs_pkg::OP_LEAF_RD;
                state_next = S_LEAF_CMP;
            end
            S_LEAF_CMP:
            begin
                cmd.op     = prs_pkg::OP_LEAF_CMP;
                state_next = S_EVAL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted during search");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_reg))
        else $error("result raised without finished search");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("finished flag outside idle state");
`endif

endmodule

@@ hw/rtl/pickup_delivery_route_search_top.sv @@
// ---------------------------------------------------------------------------
// pickup_delivery_route_search_top
// Capacitated pickup-and-delivery branch-and-bound route search.
// ---------------------------------------------------------------------------
// Usage: the input channel carries two kinds of transfer. A load transfer
// (kind 0) writes one distance entry at (row, col) of the point matrix;
// entries outside the matrix are dropped. A start transfer (kind 1) runs a
// branch-and-bound depth-first search over the routes from the depot and
// produces exactly one result transfer holding the best tour cost
// and a found flag. Every matrix entry that the search touches must have
// been loaded first.
// Sequence: a search first scans (2n+1)^2 entries for the smallest
// off-diagonal distance, then walks the route tree, skipping indices,
// backtracking, trying pickups and drops and closing complete tours; the
// result is registered once the walk ends. The single read port of the
// distance RAM sets the pace of scan and walk. Input is not taken while a
// search runs.
// Configuration: passengers and seats are written through the always-ready
// cfg channel while the block is idle; keeping to this is up to the user.
// Reset: all control state clears, passengers and seats return to one. The
// result register holds its transfer until the receiver takes it; a new
// load or start may be accepted meanwhile, and a finished search waits for
// the output register to empty.
// ---------------------------------------------------------------------------
module pickup_delivery_route_search_top (
    input logic           clk,
    input logic           rst_n,
    prs_in_if.sink        in_ch,
    prs_out_if.source     out_ch,
    prs_cfg_if.sink       cfg
);

    prs_pkg::cmd_t cmd;
    prs_pkg::sts_t sts;

    // Configuration writes land in the datapath registers directly.
    assign cfg.ready = 1'b1;

    prs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.kind),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    prs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .row       (in_ch.row),
        .col       (in_ch.col),
        .distance  (in_ch.distance),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .best_cost (out_ch.best_cost),
        .found     (out_ch.found)
    );

`ifndef SYNTH
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind == prs_pkg::KIND_LOAD && !out_ch.valid)
        |=> !out_ch.valid)
        else $error("load transfer produced a result");
    a_cost_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.found == (out_ch.best_cost != prs_pkg::COST_MAX)))
        else $error("found flag disagrees with cost");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind == prs_pkg::KIND_START) |=> !in_ch.ready)
        else $error("input ready right after start");
`endif

endmodule

@@ dv/prs_tb_if.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// prs_tb_if
// Testbench-side note: the channel interfaces of the block are reused as
// they are; this file holds the result record shared by the scoreboard.
// ---------------------------------------------------------------------------
package prs_tb_pkg;

    import prs_pkg::*;

    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic                 found;
    } route_result_t;

endpackage

@@ dv/tb_pickup_delivery_route_search_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pickup_delivery_route_search_top
// Randomized self-checking bench for the pickup-and-delivery route search.
// ---------------------------------------------------------------------------
// The whole distance matrix is loaded first, so no search ever reads an
// entry that was never written. A short directed part then covers the
// register extremes and the no-route cases, and random phases follow, each
// with its own passenger and seat setting, mixing matrix loads (some out of
// range) with search starts. A scoreboard class keeps a copy of the matrix
// and the registers and finds the cheapest feasible tour by its own depth
// first search; every result transfer is checked against the oldest
// expected route.
// ---------------------------------------------------------------------------
import prs_pkg::*;
import prs_tb_pkg::*;

class route_scoreboard;
    int unsigned   dist_mem[NUM_POINTS][NUM_POINTS];
    logic [3:0]    passengers_reg = 4'd1;
    logic [3:0]    seats_reg = 4'd1;
    route_result_t pending_routes[$];
    int            failures = 0;
    int            mismatches = 0;
    longint        best_tour;
    int            pax;

    function void write_register(logic [IDX_BITS-1:0] idx, logic [3:0] value);
        if (idx == REG_PASSENGERS)
            passengers_reg = value;
        else if (idx == REG_SEATS)
            seats_reg = value;
    endfunction

    // Branch-and-bound over partial routes; depth counts the points visited beyond the depot.
    function automatic void explore(int at, int depth, int unsigned mask,
                                    int load_now, longint cost);
        int last;
        last = 2 * pax;
        if (depth == last) begin
            if (cost + dist_mem[at][0] < best_tour)
                best_tour = cost + dist_mem[at][0];
            return;
        end
        if (cost >= best_tour)
            return;
        for (int i = 1; i <= last; i++) begin
            if (mask[i])
                continue;
            if (i <= pax) begin
                if (load_now < seats_reg && depth + 1 < last)
                    explore(i, depth + 1, mask | (1 << i), load_now + 1,
                            cost + dist_mem[at][i]);
            end
            else if (mask[i - pax]) begin
                explore(i, depth + 1, mask | (1 << i), load_now - 1,
                        cost + dist_mem[at][i]);
            end
        end
    endfunction

    function void note_transfer(logic kind, logic [4:0] row, logic [4:0] col,
                                logic [15:0] distance);
        route_result_t r;
        if (kind == KIND_LOAD) begin
            if (row < NUM_POINTS && col < NUM_POINTS)
                dist_mem[row][col] = distance;
            return;
        end
        pax = (passengers_reg > MAX_PASSENGERS) ? MAX_PASSENGERS : passengers_reg;
        best_tour = COST_MAX;
        if (pax != 0)
            explore(0, 0, 1, 0, 0);
        if (best_tour < COST_MAX) begin
            r.cost = best_tour[COST_BITS-1:0];
            r.found = 1'b1;
        end
        else begin
            r.cost = COST_MAX;
            r.found = 1'b0;
        end
        pending_routes.push_back(r);
    endfunction

    function void check_result(logic [COST_BITS-1:0] cost, logic found);
        route_result_t want;
        if (pending_routes.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: cost %0d found %0d", cost, found);
            return;
        end
        want = pending_routes.pop_front();
        if (cost !== want.cost || found !== want.found) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected cost %0d found %0d, got cost %0d found %0d",
                         want.cost, want.found, cost, found);
        end
    endfunction
endclass

module tb_pickup_delivery_route_search_top;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     TOTAL_ITEMS = 1950;

    logic clk;
    logic rst_n;

    prs_in_if  in_ch();
    prs_out_if out_ch();
    prs_cfg_if cfg();

    pickup_delivery_route_search_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    route_scoreboard routes = new();

    longint cycle_count = 0;
    int     burst_left = 0;
    int     items_sent = 0;
    int     rx_mode = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every input is known from time zero.
    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_LOAD;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.distance = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_PASSENGERS;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // The run is bounded by a generous cycle budget; hitting it is a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pickup_delivery_route_search_top test failed");
            $finish;
        end
    end

    // The receiver picks its stall pattern anew at random during the run: always
    // ready, randomly stalling, or a fixed on/off rhythm.
    always @(negedge clk) begin
        if (cycle_count % 300 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= cycle_count[2];
            default: out_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // Results are checked at the rising edge at which a transfer completes.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            routes.check_result(out_ch.best_cost, out_ch.found);
    end

    // Sends one item, in bursts of random length separated by random gaps.
    // Valid is only lowered when a gap starts or the results are drained, so a burst never toggles it.
    task automatic send_item(logic kind, logic [4:0] row, logic [4:0] col,
                             logic [15:0] distance);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 20);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.row <= row;
        in_ch.col <= col;
        in_ch.distance <= distance;
        do
            @(posedge clk);
        while (!in_ch.ready);
        routes.note_transfer(kind, row, col, distance);
        items_sent++;
    endtask

    // Holds the sender off until every expected route has arrived, then lets
    // the block settle.
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (routes.pending_routes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_register(logic [IDX_BITS-1:0] idx, logic [3:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        routes.write_register(idx, value);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic configure(logic [3:0] pax, logic [3:0] seat_count);
        drain_results();
        write_register(REG_PASSENGERS, pax);
        write_register(REG_SEATS, seat_count);
    endtask

    task automatic start_search();
        send_item(KIND_START, 5'($urandom), 5'($urandom), 16'($urandom));
    endtask

    // A random load: mostly inside the matrix, sometimes out of range, with
    // distances that are often small so the bound gets exercised.
    task automatic random_load(int span);
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] distance;
        row = $urandom_range(0, span);
        col = $urandom_range(0, span);
        if ($urandom_range(0, 15) == 0)
            row = $urandom_range(NUM_POINTS, 31);
        if ($urandom_range(0, 15) == 0)
            col = $urandom_range(NUM_POINTS, 31);
        case ($urandom_range(0, 3))
            0: distance = $urandom_range(0, 15);
            1: distance = $urandom_range(0, 1000);
            default: distance = 16'($urandom);
        endcase
        send_item(KIND_LOAD, row, col, distance);
    endtask

    initial begin
        int          pax;
        int          seat_count;
        int          phase_len;
        bit          paused_once;
        logic [15:0] d;

        paused_once = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Fill the whole matrix so that any passenger count reads written data.
        for (int r = 0; r < NUM_POINTS; r++)
            for (int c = 0; c < NUM_POINTS; c++) begin
                d = 16'($urandom);
                if (r == 0 && c == 1)
                    d = 16'hFFFF;
                else if (r == 1 && c == 2)
                    d = 16'h0000;
                send_item(KIND_LOAD, 5'(r), 5'(c), d);
            end

        // Directed part: reset registers, out-of-range loads, the no-route
        // cases and the register extremes.
        start_search();
        send_item(KIND_LOAD, 5'd31, 5'd0, 16'h1234);
        send_item(KIND_LOAD, 5'd0, 5'd23, 16'h4321);
        send_item(KIND_LOAD, 5'd23, 5'd31, 16'hAAAA);
        start_search();
        configure(4'd0, 4'd5);
        start_search();
        configure(4'd11, 4'd0);
        start_search();
        configure(4'd15, 4'd0);
        start_search();
        configure(4'd2, 4'd15);
        start_search();
        configure(4'd3, 4'd11);
        start_search();
        configure(4'd3, 4'd1);
        start_search();
        configure(4'd2, 4'd2);
        send_item(KIND_LOAD, 5'd1, 5'd3, 16'd0);
        send_item(KIND_LOAD, 5'd3, 5'd2, 16'hFFFF);
        start_search();

        // Random phases, each with its own register setting.
        while (items_sent < TOTAL_ITEMS) begin
            pax = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
            if (pax == 4)
                seat_count = $urandom_range(1, 2);
            else if ($urandom_range(0, 7) == 0)
                seat_count = ($urandom_range(0, 1) != 0) ? 0 : 15;
            else
                seat_count = $urandom_range(1, pax);
            configure(4'(pax), 4'(seat_count));
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 99) < ((pax == 4) ? 4 : 14))
                    start_search();
                else
                    random_load(2 * pax);
                if (!paused_once && k == phase_len / 2 && routes.pending_routes.size() != 0)
                begin
                    drain_results();
                    paused_once = 1'b1;
                end
            end
            start_search();
        end

        drain_results();
        repeat (40) @(posedge clk);
        routes.failures += routes.pending_routes.size();
        if (routes.failures == 0)
            $display("pickup_delivery_route_search_top test passed");
        else
            $display("pickup_delivery_route_search_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/prs_pkg.sv
hw/rtl/prs_in_if.sv
hw/rtl/prs_out_if.sv
hw/rtl/prs_cfg_if.sv
hw/rtl/prs_ram.sv
hw/rtl/prs_dp.sv
hw/rtl/prs_ctrl.sv
hw/rtl/pickup_delivery_route_search_top.sv
dv/prs_tb_if.sv
dv/tb_pickup_delivery_route_search_top.sv
